@@ hdl/command_link_responder_port_core_macros.svh @@
// Assertion macros used by the command link responder engine.
`ifndef COMMAND_LINK_RESPONDER_PORT_CORE_MACROS_SVH
`define COMMAND_LINK_RESPONDER_PORT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checks that the consequent holds in the same cycle as the antecedent.
`define CLRP_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("command link responder: check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CLRP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("command link responder: check failed");

`else

`define CLRP_ASSERT_IMPL(name, ante, cons)
`define CLRP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ hdl/clrp_pkg.sv @@
// Package with constants, types and decode tables of the command link responder.
package clrp_pkg;

	// Store geometry.
	localparam int STORE_DEPTH = 1002;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int IDX_W = $clog2(STORE_DEPTH + 1);
	localparam int EXP_BULK = 408;
	localparam int EXP_MAX = (STORE_DEPTH + 1 > EXP_BULK) ? STORE_DEPTH + 1 : EXP_BULK;
	localparam int EXP_W = $clog2(EXP_MAX + 1);
	localparam int BLK_W = 3;
	localparam int KEY_LEN = 11;
	localparam int KEY_IDX_W = $clog2(KEY_LEN);

	// Link modes.
	localparam logic [15:0] MODE_READ = 16'h0016;
	localparam logic [15:0] MODE_WRITE = 16'h0031;
	localparam logic [15:0] MODE_RESET = 16'h004E;
	localparam logic [15:0] CODE_RETRY = 16'h0015;

	// Command codes.
	localparam logic [7:0] CMD_STATUS = 8'd0;
	localparam logic [7:0] CMD_BLOCK2 = 8'd1;
	localparam logic [7:0] CMD_BULK = 8'd2;
	localparam logic [7:0] CMD_BLOCK3 = 8'd3;
	localparam logic [7:0] CMD_KEY = 8'd4;
	localparam logic [7:0] CMD_BLOCK5 = 8'd5;
	localparam logic [7:0] CMD_INVERT = 8'd6;
	localparam logic [7:0] CMD_RETRY = 8'hFE;
	localparam logic [7:0] CMD_NONE = 8'hFF;

	// Bytes and status codes.
	localparam logic [7:0] SEED_BYTE = 8'd5;
	localparam logic [7:0] ACK_ADD = 8'd5;
	localparam logic [7:0] ACK_BYTE = 8'h55;
	localparam logic [7:0] STAT_READ = 8'd2;
	localparam logic [7:0] STAT_WRITE = 8'd4;
	localparam logic [7:0] STAT_NONE = 8'd0;

	// Fixed store addresses.
	localparam logic [ADDR_W-1:0] ADDR_SEED = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_CMD = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] ADDR_ACK2 = ADDR_W'(2);

	localparam logic [EXP_W-1:0] EXP_SHORT = EXP_W'(2);

	// Memory port request.
	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0] wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// Finished item toward the output register.
	typedef struct packed {
		logic valid;
		logic [7:0] data;
	} result_t;

	// Command decode outcome.
	typedef struct packed {
		logic [EXP_W-1:0] exp;
		logic set_blk;
		logic [BLK_W-1:0] blk;
	} dec_t;

	// End-of-block adjustment.
	typedef struct packed {
		logic set_exp;
		logic [2:0] exp;
		logic add_ack;
	} eob_t;

	// Expected byte count and block count for a command byte.
	function automatic dec_t decode_cmd(input logic [7:0] cmd);
		dec_t d;
		d = '0;
		case (cmd)
			CMD_STATUS: d.exp = EXP_W'(4);
			CMD_BLOCK2: begin d.exp = EXP_W'(12); d.set_blk = 1'b1; d.blk = BLK_W'(2); end
			CMD_BULK: begin d.exp = EXP_W'(EXP_BULK); d.set_blk = 1'b1; d.blk = BLK_W'(4); end
			CMD_BLOCK3: begin d.exp = EXP_W'(7); d.set_blk = 1'b1; d.blk = BLK_W'(3); end
			CMD_KEY: begin d.exp = EXP_W'(2); d.set_blk = 1'b1; d.blk = BLK_W'(2); end
			CMD_BLOCK5: begin d.exp = EXP_W'(13); d.set_blk = 1'b1; d.blk = BLK_W'(4); end
			CMD_INVERT: d.exp = EXP_W'(STORE_DEPTH + 1);
			default: d.exp = EXP_W'(1);
		endcase
		return d;
	endfunction

	// Next expected count and ack compensation at the end of a block.
	function automatic eob_t eob_adjust(input logic [7:0] cmd, input logic [BLK_W-1:0] blk);
		eob_t e;
		e = '0;
		case (cmd)
			CMD_BLOCK2: begin
				if (blk == BLK_W'(2)) begin e.set_exp = 1'b1; e.exp = 3'd5; end
				else e.add_ack = 1'b1;
			end
			CMD_BULK: begin
				e.set_exp = 1'b1;
				if (blk == BLK_W'(4)) e.exp = 3'd5;
				else begin e.add_ack = 1'b1; e.exp = 3'd3; end
			end
			CMD_BLOCK3: begin
				e.set_exp = 1'b1;
				if (blk == BLK_W'(3)) e.exp = 3'd3;
				else begin e.add_ack = 1'b1; e.exp = 3'd5; end
			end
			CMD_BLOCK5: begin
				e.set_exp = 1'b1;
				e.exp = 3'd3;
				if (blk < BLK_W'(4)) begin
					e.add_ack = 1'b1;
					if (blk == BLK_W'(2)) e.exp = 3'd2;
				end
			end
			default: e = '0;
		endcase
		return e;
	endfunction

	// Password bytes.
	function automatic logic [7:0] key_byte(input logic [KEY_IDX_W-1:0] pos);
		logic [7:0] b;
		case (pos)
			KEY_IDX_W'(0): b = 8'd5;
			KEY_IDX_W'(1): b = 8'd2;
			KEY_IDX_W'(2): b = 8'd0;
			KEY_IDX_W'(3): b = 8'd3;
			KEY_IDX_W'(4): b = 8'd0;
			KEY_IDX_W'(5): b = 8'd0;
			KEY_IDX_W'(6): b = 8'd2;
			KEY_IDX_W'(7): b = 8'd4;
			KEY_IDX_W'(8): b = 8'd5;
			KEY_IDX_W'(9): b = 8'd6;
			KEY_IDX_W'(10): b = 8'h16;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

@@ hdl/clrp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module clrp_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// Read port, registered read data.
	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/clrp_engine.sv @@
// Protocol sequencer: decodes each item and reads, modifies and writes the byte store.
`include "command_link_responder_port_core_macros.svh"

module clrp_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               opcode,
	input  logic               port_select,
	input  logic               low_byte_enabled,
	input  logic [15:0]        write_data,
	output clrp_pkg::ram_req_t ram_req,
	input  logic [7:0]         ram_rdata,
	input  logic               out_free,
	output clrp_pkg::result_t  result
);
	import clrp_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_BODY  = 4'd3;
	localparam logic [3:0] S_SWEEP = 4'd4;
	localparam logic [3:0] S_W55A  = 4'd5;
	localparam logic [3:0] S_W55B  = 4'd6;
	localparam logic [3:0] S_FETCH = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q;
	logic clear_q;
	logic [ADDR_W-1:0] clr_q;

	// Captured item.
	logic op_q, port_q, lane_q;
	logic [15:0] wdata_q;

	// Protocol state.
	logic [15:0] mode_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0] cmd_q;
	logic [EXP_W-1:0] exp_q;
	logic [BLK_W-1:0] blk_q;
	logic ack_q;

	// Sweep state.
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] end_q;
	logic key_mode_q;
	logic miss_q;
	logic [7:0] sum_q;
	logic rvld_s1;
	logic [KEY_IDX_W-1:0] key_pos_s1;

	logic [7:0] res_q;

	logic accept;
	logic [IDX_W-1:0] idx_inc;
	logic wr_gate, wr_ok;
	logic [7:0] wr_byte;
	logic dec_go, in_range, eob;
	logic sweep_issue, sweep_done;
	eob_t eob_adj;
	dec_t dec;
	logic [7:0] sum_fin;
	logic [7:0] status;

	assign req_stall = (state_q != S_IDLE) || clear_q;
	assign accept = req_valid && !req_stall;

	// Shared decisions for the current item.
	assign idx_inc = idx_q + IDX_W'(1);
	assign wr_gate = (mode_q == MODE_WRITE) && (idx_q < IDX_W'(STORE_DEPTH - 2));
	assign wr_ok = wr_gate && (!ack_q || (wdata_q == CODE_RETRY));
	assign wr_byte = (cmd_q == CMD_INVERT) ? ~wdata_q[7:0] : (ack_q ? SEED_BYTE : wdata_q[7:0]);
	assign dec_go = (idx_q == '0) && (cmd_q == CMD_NONE);
	assign in_range = idx_q < IDX_W'(STORE_DEPTH);
	assign eob = exp_q == EXP_W'(1);
	assign sweep_issue = ptr_q != end_q;
	assign sweep_done = !sweep_issue && !rvld_s1;
	assign eob_adj = eob_adjust(cmd_q, blk_q);
	assign dec = decode_cmd(ram_rdata);
	assign sum_fin = sum_q + (eob_adj.add_ack ? ACK_ADD : 8'd0);
	assign status = (mode_q == MODE_READ) ? STAT_READ :
		((mode_q == MODE_WRITE) ? STAT_WRITE : STAT_NONE);

	assign result.valid = state_q == S_OUT;
	assign result.data = res_q;

	// Store requests for each step.
	always_comb begin
		ram_req = '0;
		if (clear_q) begin
			ram_req.we = 1'b1;
			ram_req.waddr = clr_q;
			ram_req.wdata = 8'd0;
		end
		case (state_q)
			S_EXEC: begin
				if (op_q && port_q) begin
					if ((mode_q != wdata_q) && (wdata_q == MODE_RESET)) begin
						ram_req.we = 1'b1;
						ram_req.waddr = ADDR_SEED;
						ram_req.wdata = SEED_BYTE;
					end
				end else if (op_q) begin
					if (wr_ok) begin
						ram_req.we = 1'b1;
						ram_req.waddr = idx_inc[ADDR_W-1:0];
						ram_req.wdata = wr_byte;
					end
				end else if (!port_q && lane_q && (mode_q == MODE_READ) && dec_go) begin
					ram_req.re = 1'b1;
					ram_req.raddr = ADDR_CMD;
				end
			end
			S_BODY: begin
				if (in_range && (!eob || ((idx_q == '0) && (cmd_q != CMD_KEY)))) begin
					ram_req.re = 1'b1;
					ram_req.raddr = idx_q[ADDR_W-1:0];
				end
			end
			S_SWEEP: begin
				if (sweep_issue) begin
					ram_req.re = 1'b1;
					ram_req.raddr = ptr_q[ADDR_W-1:0];
				end
				if (sweep_done && !key_mode_q) begin
					ram_req.we = 1'b1;
					ram_req.waddr = idx_q[ADDR_W-1:0];
					ram_req.wdata = sum_fin;
				end
			end
			S_W55A: begin
				ram_req.we = 1'b1;
				ram_req.waddr = ADDR_CMD;
				ram_req.wdata = ACK_BYTE;
			end
			S_W55B: begin
				ram_req.we = 1'b1;
				ram_req.waddr = ADDR_ACK2;
				ram_req.wdata = ACK_BYTE;
			end
			default: ram_req.re = 1'b0;
		endcase
	end

	// Captured item fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			port_q <= port_select;
			lane_q <= low_byte_enabled;
			wdata_q <= write_data;
		end
	end

	// Sequencer and protocol state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clear_q <= 1'b1;
			clr_q <= '0;
			mode_q <= '0;
			idx_q <= '0;
			cmd_q <= CMD_NONE;
			exp_q <= '0;
			blk_q <= '0;
			ack_q <= 1'b0;
			ptr_q <= '0;
			end_q <= '0;
			key_mode_q <= 1'b0;
			miss_q <= 1'b0;
			sum_q <= '0;
			rvld_s1 <= 1'b0;
			key_pos_s1 <= '0;
			res_q <= '0;
		end else begin
			// Clearing pass over the store after reset.
			if (clear_q) begin
				clr_q <= clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) clear_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_q <= STAT_NONE;
					state_q <= S_OUT;
					if (op_q && port_q) begin
						mode_q <= wdata_q;
						if (mode_q != wdata_q) begin
							idx_q <= '0;
							if (wdata_q == MODE_RESET) begin
								cmd_q <= CMD_NONE;
								exp_q <= '0;
								blk_q <= '0;
								ack_q <= 1'b0;
							end
						end
					end else if (op_q) begin
						if (wr_gate) begin
							ack_q <= 1'b0;
							if (wr_ok) begin
								idx_q <= idx_inc;
								if ((cmd_q != CMD_INVERT) && ack_q) begin
									cmd_q <= CMD_RETRY;
									exp_q <= EXP_SHORT;
								end
							end
						end
					end else if (port_q) begin
						res_q <= status;
					end else if (lane_q && (mode_q == MODE_READ)) begin
						state_q <= dec_go ? S_DEC : S_BODY;
					end
				end
				S_DEC: begin
					cmd_q <= ram_rdata;
					exp_q <= dec.exp;
					if (dec.set_blk) blk_q <= dec.blk;
					state_q <= S_BODY;
				end
				S_BODY: begin
					if (!in_range) begin
						res_q <= STAT_NONE;
						state_q <= S_OUT;
					end else begin
						state_q <= S_FETCH;
						if (exp_q != '0) exp_q <= exp_q - EXP_W'(1);
						if (eob) begin
							ack_q <= 1'b1;
							if ((idx_q != '0) || (cmd_q == CMD_KEY)) begin
								// Walk the store: checksum or password compare.
								state_q <= S_SWEEP;
								key_mode_q <= idx_q == '0;
								ptr_q <= (idx_q == '0) ? '0 : IDX_W'(1);
								end_q <= (idx_q == '0) ? IDX_W'(KEY_LEN) : idx_q;
								miss_q <= 1'b0;
								sum_q <= '0;
								rvld_s1 <= 1'b0;
							end else begin
								if (blk_q <= BLK_W'(1)) cmd_q <= CMD_NONE;
								if (blk_q != '0) blk_q <= blk_q - BLK_W'(1);
							end
						end
					end
				end
				S_SWEEP: begin
					// Consume the byte read in the previous cycle.
					if (rvld_s1) begin
						if (key_mode_q) begin
							if (ram_rdata != key_byte(key_pos_s1)) miss_q <= 1'b1;
							if (key_pos_s1 == '0) res_q <= ram_rdata;
						end else begin
							sum_q <= sum_q + ram_rdata;
						end
					end
					rvld_s1 <= sweep_issue;
					key_pos_s1 <= ptr_q[KEY_IDX_W-1:0];
					if (sweep_issue) ptr_q <= ptr_q + IDX_W'(1);
					if (sweep_done) begin
						idx_q <= idx_inc;
						if (blk_q <= BLK_W'(1)) cmd_q <= CMD_NONE;
						if (blk_q != '0) blk_q <= blk_q - BLK_W'(1);
						if (key_mode_q) begin
							exp_q <= EXP_SHORT;
							ack_q <= 1'b0;
							state_q <= miss_q ? S_OUT : S_W55A;
						end else begin
							if (eob_adj.set_exp) exp_q <= EXP_W'(eob_adj.exp);
							res_q <= sum_fin;
							state_q <= S_OUT;
						end
					end
				end
				S_W55A: state_q <= S_W55B;
				S_W55B: state_q <= S_OUT;
				S_FETCH: begin
					res_q <= ram_rdata;
					idx_q <= idx_inc;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CLRP_ASSERT_IMPL(a_no_rw_collide, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr)
	`CLRP_ASSERT_IMPL(a_idx_bound, 1'b1, idx_q <= IDX_W'(STORE_DEPTH))
	`CLRP_ASSERT_IMPL(a_sweep_bound, state_q == S_SWEEP, ptr_q <= end_q)
	`CLRP_ASSERT_IMPL(a_key_at_zero, (state_q == S_SWEEP) && key_mode_q, idx_q == '0)
	`CLRP_ASSERT_NEXT(a_accept_exec, accept, state_q == S_EXEC)

endmodule

@@ hdl/command_link_responder_port_core.sv @@
// Top level of the command link responder: sequencer, byte store and output register.
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+-------------------------------------------------
//  request | req_valid | req_stall | opcode, port_select, low_byte_enabled, write_data
//  result  | rsp_valid | rsp_stall | read_data
//
// Writes and status reads finish after the execute step; data reads add decode (if due), body and fetch.
// The last read of a checksum block walks the store one byte a cycle, from address 1 up to the index.
// The password check reads 11 bytes and, when they match, writes two acknowledge bytes.
// After reset, a clearing pass zeroes the store; no item is taken until it ends.
// A stalled result sits in the output register; the next item is taken meanwhile.
module command_link_responder_port_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        opcode,
	input  logic        port_select,
	input  logic        low_byte_enabled,
	input  logic [15:0] write_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  read_data
);
	import clrp_pkg::*;

	ram_req_t ram_req;
	result_t result;
	logic [7:0] ram_rdata;
	logic out_free;
	logic out_valid_q;
	logic [7:0] read_data_q;

	assign out_free = !out_valid_q || !rsp_stall;

	clrp_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.opcode           (opcode),
		.port_select      (port_select),
		.low_byte_enabled (low_byte_enabled),
		.write_data       (write_data),
		.ram_req          (ram_req),
		.ram_rdata        (ram_rdata),
		.out_free         (out_free),
		.result           (result)
	);

	clrp_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (8)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result byte.
	always_ff @(posedge clk) begin
		if (result.valid && out_free) read_data_q <= result.data;
	end

	assign rsp_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule
